FILE: hw/rtl/stepper_position_profile_defines.svh
// assertion macros for the port-level checker
`ifndef STEPPER_POSITION_PROFILE_DEFINES_SVH
`define STEPPER_POSITION_PROFILE_DEFINES_SVH

// property that must hold at every edge outside reset
`define SPP_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent that must hold at the next edge after the antecedent
`define SPP_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/spp_pkg.sv
// shared constants, types and step-period tables of the stepper position profile
package spp_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int POS_WIDTH_DEF   = 24;

  localparam int FIELD_POS_W = 24;
  localparam int PERIOD_W    = 12;
  localparam int ACCEL_W     = 8;
  localparam int DIVIDEND_W  = 24;
  localparam int DIVISOR_W   = 9;
  localparam int TAB_IDX_W   = 6;
  localparam int TAB_ENTRIES = 32;
  localparam int TAB_SEL_W   = $clog2(TAB_ENTRIES);
  localparam int S_TDATA_W   = 32;
  localparam int M_TDATA_W   = 40;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [DIVISOR_W-1:0]   STEP_DIVISOR  = 9'd100;
  localparam logic [ACCEL_W-1:0]     ACCEL_RESET   = 8'd150;
  localparam logic [FIELD_POS_W-1:0] MAX_POS_RESET = 24'd100000;
  localparam logic [PERIOD_W-1:0]    PERIOD_MAX    = 12'd3000;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PROFILE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_POS = 2'd2;

  // control phases
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_RAMP = 2'd1;
  localparam logic [1:0] PH_TRIM = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  localparam logic [PERIOD_W-1:0] LIN_TAB [0:TAB_ENTRIES-1] = '{
    12'd448, 12'd448, 12'd224, 12'd149, 12'd112, 12'd90, 12'd75, 12'd64,
    12'd56, 12'd50, 12'd45, 12'd41, 12'd37, 12'd34, 12'd32, 12'd30,
    12'd28, 12'd26, 12'd25, 12'd24, 12'd22, 12'd21, 12'd20, 12'd19,
    12'd19, 12'd18, 12'd17, 12'd17, 12'd16, 12'd15, 12'd15, 12'd14
  };

  localparam logic [PERIOD_W-1:0] EXP_TAB [0:TAB_ENTRIES-1] = '{
    12'd3000, 12'd3000, 12'd1593, 12'd896, 12'd573, 12'd398, 12'd293, 12'd224,
    12'd177, 12'd143, 12'd118, 12'd100, 12'd85, 12'd73, 12'd64, 12'd56,
    12'd50, 12'd44, 12'd40, 12'd36, 12'd33, 12'd30, 12'd27, 12'd25,
    12'd23, 12'd21, 12'd20, 12'd18, 12'd17, 12'd16, 12'd15, 12'd14
  };

  // indexes past the table use its last entry
  function automatic logic [PERIOD_W-1:0] period_of(input logic [TAB_IDX_W-1:0] idx,
                                                    input logic expo);
    logic [TAB_SEL_W-1:0] sel;
    sel = (idx >= TAB_IDX_W'(TAB_ENTRIES)) ? TAB_SEL_W'(TAB_ENTRIES - 1) : idx[TAB_SEL_W-1:0];
    return expo ? EXP_TAB[sel] : LIN_TAB[sel];
  endfunction

endpackage

FILE: hw/rtl/spp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module spp_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [spp_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [spp_pkg::DIVISOR_W-1:0]   divisor,
  output logic [spp_pkg::DIVIDEND_W-1:0]  quotient,
  output spp_pkg::div_stat_t              stat
);

  localparam int DW  = spp_pkg::DIVIDEND_W;
  localparam int VW  = spp_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo;
  logic [VW-1:0]    rem;
  logic [VW-1:0]    dvs;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             ge;

  // shift the next dividend bit into the partial remainder
  always_comb begin
    trial = {rem, quo[DW-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DW-2:0], ge};
      rem <= ge ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: hw/rtl/stepper_position_profile.sv
// stepper position profile: setpoint tracking and speed ramp over a step-period table
// sequence: an input transfer passes PREP, DIV when a divide is needed (phase 0 with a
//   pending detent, or the ramp phase), UPD, DIR for a setpoint move, and DONE, which
//   loads the result once the output is free; one item in flight at a time; divides use the bit-serial divider
// a finished result waits in the output register while the next item is taken
// reset: synchronous; setpoint, phase, index, ms counter and direction clear, config to defaults
module stepper_position_profile #(
  parameter int TABLE_DEPTH = spp_pkg::TABLE_DEPTH_DEF,
  parameter int POS_WIDTH   = spp_pkg::POS_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // tdata: ms_tick[0], enc_event[1], enc_cw[2], position[26:3], zero fill
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [spp_pkg::S_TDATA_W-1:0]   s_tdata,
  // tdata: step_period[11:0], period_write[12], spin_cw[13], dir_write[14],
  //        target[38:15], zero fill
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [spp_pkg::M_TDATA_W-1:0]   m_tdata,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [spp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PW    = spp_pkg::FIELD_POS_W;
  localparam int DW    = spp_pkg::DIVIDEND_W;
  localparam int AW    = spp_pkg::ACCEL_W;
  localparam int TAB_W = spp_pkg::TAB_IDX_W;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] CAP = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [PW-1:0] POS_MASK =
    (POS_WIDTH >= PW) ? {PW{1'b1}} : PW'((64'd1 << POS_WIDTH) - 64'd1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_DIR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // config registers
  logic          profile_exp;
  logic [AW-1:0] accel;
  logic [PW-1:0] max_pos;

  // loop state
  logic [2:0]       state;
  logic [PW-1:0]    target_reg;
  logic [1:0]       phase;
  logic [IDX_W-1:0] last_index;
  logic [AW-1:0]    ms_count;
  logic             ev_pend;
  logic             pend_cw;
  logic             dir_reg;

  // per-item working values
  logic [PW-1:0]               pos_q;
  logic [spp_pkg::PERIOD_W-1:0] res_period;
  logic                        res_pw;
  logic                        res_dw;

  // input field unpacking
  logic          in_tick;
  logic          in_evt;
  logic          in_cw;
  logic [PW-1:0] in_pos;

  // divider hookup
  logic                              div_start;
  logic [DW-1:0]                     div_dividend;
  logic [spp_pkg::DIVISOR_W-1:0]     div_divisor;
  logic [DW-1:0]                     quotient;
  spp_pkg::div_stat_t                div_stat;

  // datapath
  logic                         need_div;
  logic [PW-1:0]                mag;
  logic [PW:0]                  sum_up;
  logic [PW-1:0]                up_val;
  logic [PW-1:0]                dn_val;
  logic [IDX_W-1:0]             n_raw;
  logic [IDX_W-1:0]             n_sel;
  logic                         rise;
  logic [spp_pkg::PERIOD_W-1:0] period_lu;
  logic                         out_load;

  assign in_tick = s_tdata[0];
  assign in_evt  = s_tdata[1];
  assign in_cw   = s_tdata[2];
  assign in_pos  = s_tdata[PW+2:3];

  // a new item only when the sequencer is back at rest
  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    // phase 0 divides the limit by 100 for the setpoint step,
    // the ramp phase divides the error magnitude by twice accel
    need_div = ((phase == spp_pkg::PH_WAIT) && ev_pend) || (phase == spp_pkg::PH_RAMP);
    mag      = (target_reg >= pos_q) ? (target_reg - pos_q) : (pos_q - target_reg);
    if (phase == spp_pkg::PH_WAIT) begin
      div_dividend = max_pos;
      div_divisor  = spp_pkg::STEP_DIVISOR;
    end else begin
      div_dividend = mag;
      div_divisor  = {accel, 1'b0};
    end
    div_start = (state == S_PREP) && need_div && !div_stat.busy;

    // setpoint move, clockwise clamps at the limit, counter-clockwise at zero
    sum_up = {1'b0, target_reg} + {1'b0, quotient[PW-1:0]};
    up_val = (sum_up >= {1'b0, max_pos}) ? max_pos : sum_up[PW-1:0];
    dn_val = (target_reg > quotient[PW-1:0]) ? (target_reg - quotient[PW-1:0]) : '0;

    // speed index, capped, and allowed to rise one step at a time
    // (zero accel gives an all-ones quotient, which also caps)
    n_raw     = (quotient > DW'(CAP)) ? CAP : quotient[IDX_W-1:0];
    rise      = n_raw > last_index;
    n_sel     = rise ? (last_index + IDX_W'(1)) : n_raw;
    period_lu = spp_pkg::period_of(TAB_W'(n_sel), profile_exp);

    out_load  = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  spp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      profile_exp <= 1'b0;
      accel       <= spp_pkg::ACCEL_RESET;
      max_pos     <= spp_pkg::MAX_POS_RESET;
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      target_reg  <= '0;
      phase       <= spp_pkg::PH_WAIT;
      last_index  <= '0;
      ms_count    <= '0;
      ev_pend     <= 1'b0;
      pend_cw     <= 1'b0;
      dir_reg     <= 1'b0;
      res_period  <= '0;
      res_pw      <= 1'b0;
      res_dw      <= 1'b0;
    end else begin
      // config writes take effect at once; the driver must write only between items, unenforced by the block
      if (cfg_valid) begin
        unique case (cfg_index)
          spp_pkg::REG_PROFILE: profile_exp <= cfg_data[0];
          spp_pkg::REG_ACCEL:   accel       <= cfg_data[AW-1:0];
          spp_pkg::REG_MAX_POS: max_pos     <= cfg_data[PW-1:0];
          default: ;
        endcase
      end

      // output valid: set on a load, cleared once the held result transfers
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            // tick and detent are folded in before the phase step
            if (in_tick && (ms_count != {AW{1'b1}})) begin
              ms_count <= ms_count + AW'(1);
            end
            if (in_evt) begin
              ev_pend <= 1'b1;
              pend_cw <= in_cw;
            end
            res_period <= '0;
            res_pw     <= 1'b0;
            res_dw     <= 1'b0;
            state      <= S_PREP;
          end
        end
        S_PREP: begin
          state <= need_div ? S_DIV : S_UPD;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          // a setpoint move still has the direction to settle
          state <= ((phase == spp_pkg::PH_WAIT) && ev_pend) ? S_DIR : S_DONE;
          unique case (phase)
            spp_pkg::PH_WAIT: begin
              if (ev_pend) begin
                ev_pend    <= 1'b0;
                target_reg <= pend_cw ? up_val : dn_val;
                phase      <= spp_pkg::PH_RAMP;
              end
            end
            spp_pkg::PH_RAMP: begin
              if (rise) begin
                if (ms_count >= accel) begin
                  ms_count   <= '0;
                  last_index <= n_sel;
                end
              end else begin
                last_index <= n_raw;
              end
              // a pending detent wins over entering trim
              if (ev_pend) begin
                phase <= spp_pkg::PH_WAIT;
              end else if (n_sel == '0) begin
                phase <= spp_pkg::PH_TRIM;
              end
              res_period <= period_lu;
              res_pw     <= 1'b1;
            end
            spp_pkg::PH_TRIM: begin
              if (target_reg != pos_q) begin
                if (ev_pend) begin
                  phase <= spp_pkg::PH_WAIT;
                end
              end else begin
                // on target: stop the motor
                res_period <= '0;
                res_pw     <= 1'b1;
                ms_count   <= '0;
                phase      <= spp_pkg::PH_WAIT;
              end
            end
            default: begin
              phase <= spp_pkg::PH_WAIT;
            end
          endcase
        end
        S_DIR: begin
          // direction follows the sign of the new error, unchanged at zero
          if (target_reg > pos_q) begin
            dir_reg <= 1'b1;
            res_dw  <= 1'b1;
          end else if (target_reg < pos_q) begin
            dir_reg <= 1'b0;
            res_dw  <= 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pos_q <= in_pos & POS_MASK;
    end
    if (out_load) begin
      m_tdata <= {1'b0, target_reg & POS_MASK, res_dw, dir_reg, res_pw, res_period};
    end
  end

endmodule

FILE: hw/rtl/stepper_position_profile_checker.sv
// port-level checker for the stepper position profile, bound to the top level
`include "stepper_position_profile_defines.svh"

module stepper_position_profile_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [spp_pkg::M_TDATA_W-1:0] m_tdata
);

  logic [spp_pkg::PERIOD_W-1:0] period;
  logic                         pwrite;
  logic                         dwrite;

  assign period = m_tdata[11:0];
  assign pwrite = m_tdata[12];
  assign dwrite = m_tdata[14];

  `SPP_CHECK(a_period_zero_unwritten, (m_tvalid && !pwrite) |-> (period == '0), "period without write")
  `SPP_CHECK(a_period_range, m_tvalid |-> (period <= spp_pkg::PERIOD_MAX), "period out of range")
  `SPP_CHECK(a_single_write, m_tvalid |-> !(pwrite && dwrite), "period and direction in one item")
  `SPP_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second transfer back to back")
  `SPP_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

endmodule

bind stepper_position_profile stepper_position_profile_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
